/* rtl/ftt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ftt_pkg
// Shared types, constants and the TCP state step for the flow table tracker.
// ============================================================================
package ftt_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 64;

    // Field widths
    localparam int ENDPOINT_W = 48;
    localparam int PROTO_W    = 8;
    localparam int PKT_CNT_W  = 32;
    localparam int BYTE_CNT_W = 48;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 16;
    localparam int FLAGS_W    = 4;
    localparam int OUT_IDX_W  = 6;
    localparam int OUT_EST_W  = 7;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam int                 EST_SAT   = 127;

    // TCP flag bit positions
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 3;

    typedef enum logic [2:0] {
        TCP_NONE        = 3'd0,
        TCP_SYN_SENT    = 3'd1,
        TCP_SYN_ACK     = 3'd2,
        TCP_ESTABLISHED = 3'd3,
        TCP_CLOSING     = 3'd4,
        TCP_CLOSED      = 3'd5
    } tcp_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DROP
    } ftt_state_t;

    // One table row: key plus flow record
    typedef struct packed {
        logic [ENDPOINT_W-1:0] key_lo;
        logic [ENDPOINT_W-1:0] key_hi;
        logic [PROTO_W-1:0]    key_proto;
        logic [PKT_CNT_W-1:0]  pkt_cnt;
        logic [BYTE_CNT_W-1:0] byte_cnt;
        logic [TIME_W-1:0]     first_time;
        logic [TIME_W-1:0]     last_time;
        tcp_state_t            tcp_state;
    } entry_row_t;

    // Per-packet fields the record update needs
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [TIME_W-1:0]  ts;
        logic               is_tcp;
        logic [FLAGS_W-1:0] flags;
        logic [PROTO_W-1:0] proto;
    } pkt_info_t;

    // Established counter adjustment
    typedef struct packed {
        logic inc;
        logic dec;
    } est_delta_t;

    // Simplified TCP transition, first matching rule wins
    function automatic tcp_state_t step_state(input tcp_state_t cur,
                                              input logic [FLAGS_W-1:0] flags);
        tcp_state_t nxt;
        nxt = cur;
        priority if (flags[FLAG_RST])
            nxt = TCP_CLOSED;
        else if (flags[FLAG_SYN] && !flags[FLAG_ACK])
            nxt = TCP_SYN_SENT;
        else if (flags[FLAG_SYN] && flags[FLAG_ACK])
            nxt = TCP_SYN_ACK;
        else if (flags[FLAG_FIN])
            nxt = (cur == TCP_CLOSING) ? TCP_CLOSED : TCP_CLOSING;
        else if (flags[FLAG_ACK] && (cur == TCP_SYN_ACK || cur == TCP_SYN_SENT ||
                                     cur == TCP_NONE))
            nxt = TCP_ESTABLISHED;
        else if (cur == TCP_NONE)
            nxt = TCP_ESTABLISHED;
        else
            nxt = cur;
        return nxt;
    endfunction

endpackage
`default_nettype wire

/* rtl/ftt_pkt_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ftt_pkt_if
// Packet summary channel: valid/ready handshake with header fields.
// ============================================================================
interface ftt_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol_number;
    logic        is_tcp_segment;
    logic [3:0]  tcp_flag_bits;
    logic [15:0] frame_length;
    logic [31:0] arrival_time;

    modport source (
        output valid, source_address, dest_address, source_port, dest_port,
               protocol_number, is_tcp_segment, tcp_flag_bits, frame_length,
               arrival_time,
        input  ready
    );

    modport sink (
        input  valid, source_address, dest_address, source_port, dest_port,
               protocol_number, is_tcp_segment, tcp_flag_bits, frame_length,
               arrival_time,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/ftt_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ftt_res_if
// Flow result channel: valid/ready handshake with the flow record fields.
// ============================================================================
interface ftt_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_index;
    logic        created_flow;
    logic        table_full_drop;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic [2:0]  connection_state;
    logic [6:0]  established_count;

    modport source (
        output valid, entry_index, created_flow, table_full_drop, packet_total,
               byte_total, first_time, last_time, connection_state,
               established_count,
        input  ready
    );

    modport sink (
        input  valid, entry_index, created_flow, table_full_drop, packet_total,
               byte_total, first_time, last_time, connection_state,
               established_count,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/ftt_entry_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ftt_entry_ram
// Flow table row storage: one write port, one registered read port.
// ============================================================================
module ftt_entry_ram
    import ftt_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(TABLE_ENTRIES_DEF)
)
(
    input  wire              clk,
    input  wire              we,
    input  wire  [IDX_W-1:0] waddr,
    input  entry_row_t       wdata,
    input  wire              re,
    input  wire  [IDX_W-1:0] raddr,
    output entry_row_t       rdata
);

    entry_row_t mem [DEPTH];
    entry_row_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/ftt_flow_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ftt_flow_update
// Record update: saturating counters, timestamps and the TCP state step.
// ============================================================================
module ftt_flow_update
    import ftt_pkg::*;
(
    input  entry_row_t base_row,
    input  pkt_info_t  info,
    input  wire        est_nonzero,
    output entry_row_t new_row,
    output est_delta_t est_delta
);

    logic [BYTE_CNT_W:0] byte_sum;
    tcp_state_t          stepped_state;
    logic                counted;

    assign byte_sum      = {1'b0, base_row.byte_cnt} + (BYTE_CNT_W + 1)'(info.len);
    assign stepped_state = info.is_tcp ? step_state(base_row.tcp_state, info.flags)
                                       : base_row.tcp_state;
    assign counted       = info.is_tcp && (base_row.key_proto == PROTO_TCP);

    // New record
    always_comb
    begin
        new_row           = base_row;
        new_row.pkt_cnt   = (&base_row.pkt_cnt) ? base_row.pkt_cnt
                                                : base_row.pkt_cnt + 1'b1;
        new_row.byte_cnt  = byte_sum[BYTE_CNT_W] ? {BYTE_CNT_W{1'b1}}
                                                 : byte_sum[BYTE_CNT_W-1:0];
        new_row.last_time = info.ts;
        new_row.tcp_state = stepped_state;
    end

    // Established transitions, only for protocol 6 flows
    always_comb
    begin
        est_delta.dec = counted && (base_row.tcp_state == TCP_ESTABLISHED) &&
                        (stepped_state != TCP_ESTABLISHED) && est_nonzero;
        est_delta.inc = counted && (base_row.tcp_state != TCP_ESTABLISHED) &&
                        (stepped_state == TCP_ESTABLISHED);
    end

endmodule
`default_nettype wire

/* rtl/flow_table_tcp_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// flow_table_tcp_tracker
// Bidirectional flow table with saturating counters and TCP state tracking.
// ============================================================================
// One packet summary in, one flow result out. The two endpoints are ordered
// so both directions share a key, and the table is searched one entry per
// clock through the single read port of the entry memory, from entry 0 up
// to entry F - 1, F being the number of flows held so far, until a key
// matches. A match or, after the last read has been compared, a new row
// moves to the update state, which writes the row and loads the result once
// the output register is free; an unknown flow on a full table goes to the
// drop state instead. The block is ready again in the cycle after the
// result is loaded, so it takes no new packet while one is in flight.
// Entries are allocated in order and never freed, so a fill count marks the
// live rows and no clearing pass is needed after reset. A new packet is
// accepted while the previous result still waits in the output register.
// When the flow is unknown and the table is full the packet is dropped with
// table_full_drop set and nothing is updated.
module flow_table_tcp_tracker
    import ftt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire       clk,
    input  wire       rst_n,
    ftt_pkt_if.sink   pkt,
    ftt_res_if.source res
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    ftt_state_t state_reg, state_next;

    // Captured packet
    logic [ENDPOINT_W-1:0] lo_reg, hi_reg;
    pkt_info_t             info_reg;

    // Scan control
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Table bookkeeping
    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0] est_cnt_reg, est_cnt_next;

    // Selected row
    entry_row_t       base_row_reg, base_row_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             is_new_reg, is_new_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]  out_idx_reg;
    logic                  out_created_reg, out_drop_reg;
    logic [PKT_CNT_W-1:0]  out_pkt_reg;
    logic [BYTE_CNT_W-1:0] out_byte_reg;
    logic [TIME_W-1:0]     out_first_reg, out_last_reg;
    logic [2:0]            out_state_reg;
    logic [OUT_EST_W-1:0]  out_est_reg;

    logic                  accept;
    logic                  go;
    logic                  match;
    logic                  rd_en;
    logic                  wr_en;
    logic                  load_res;
    logic                  load_drop;
    entry_row_t            rd_row;
    entry_row_t            new_row;
    entry_row_t            fresh_row;
    est_delta_t            est_delta;
    logic [ENDPOINT_W-1:0] src_ep, dst_ep;
    logic                  src_low;
    logic [CNT_W-1:0]      est_after;

    assign accept = pkt.valid && pkt.ready;
    assign go     = !out_valid_reg || res.ready;

    // Endpoint ordering at acceptance
    assign src_ep  = {pkt.source_address, pkt.source_port};
    assign dst_ep  = {pkt.dest_address, pkt.dest_port};
    assign src_low = (src_ep <= dst_ep);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg         <= src_low ? src_ep : dst_ep;
            hi_reg         <= src_low ? dst_ep : src_ep;
            info_reg.len    <= pkt.frame_length;
            info_reg.ts     <= pkt.arrival_time;
            info_reg.is_tcp <= pkt.is_tcp_segment;
            info_reg.flags  <= pkt.tcp_flag_bits;
            info_reg.proto  <= pkt.protocol_number;
        end
    end

    // Key compare on the row read last cycle
    assign match = rd_pend_reg && (rd_row.key_lo == lo_reg) &&
                   (rd_row.key_hi == hi_reg) && (rd_row.key_proto == info_reg.proto);

    // Row for a newly allocated flow
    always_comb
    begin
        fresh_row            = '0;
        fresh_row.key_lo     = lo_reg;
        fresh_row.key_hi     = hi_reg;
        fresh_row.key_proto  = info_reg.proto;
        fresh_row.first_time = info_reg.ts;
        fresh_row.last_time  = info_reg.ts;
        fresh_row.tcp_state  = TCP_NONE;
    end

    ftt_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (hit_idx_reg),
        .wdata (new_row),
        .re    (rd_en),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_row)
    );

    ftt_flow_update u_update (
        .base_row    (base_row_reg),
        .info        (info_reg),
        .est_nonzero (est_cnt_reg != '0),
        .new_row     (new_row),
        .est_delta   (est_delta)
    );

    always_comb
    begin
        est_after = est_cnt_reg;
        if (est_delta.inc)
            est_after = est_cnt_reg + 1'b1;
        else if (est_delta.dec)
            est_after = est_cnt_reg - 1'b1;
    end

    // State register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            fill_cnt_reg  <= '0;
            est_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            fill_cnt_reg  <= fill_cnt_next;
            est_cnt_reg   <= est_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload-side registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        base_row_reg <= base_row_next;
        hit_idx_reg  <= hit_idx_next;
        is_new_reg   <= is_new_next;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        rd_pend_next  = 1'b0;
        rd_idx_next   = rd_idx_reg;
        base_row_next = base_row_reg;
        hit_idx_next  = hit_idx_reg;
        is_new_next   = is_new_reg;
        fill_cnt_next = fill_cnt_reg;
        est_cnt_next  = est_cnt_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        load_res      = 1'b0;
        load_drop     = 1'b0;
        pkt.ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pkt.ready     = 1'b1;
                scan_idx_next = '0;
                if (accept)
                    state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    base_row_next = rd_row;
                    hit_idx_next  = rd_idx_reg;
                    is_new_next   = 1'b0;
                    state_next    = ST_UPDATE;
                end
                else if (scan_idx_reg < fill_cnt_reg)
                begin
                    rd_en         = 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    // Unknown flow: allocate the next row or drop
                    if (fill_cnt_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        base_row_next = fresh_row;
                        hit_idx_next  = fill_cnt_reg[IDX_W-1:0];
                        is_new_next   = 1'b1;
                        state_next    = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_DROP;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (go)
                begin
                    wr_en        = 1'b1;
                    load_res     = 1'b1;
                    est_cnt_next = est_after;
                    if (is_new_reg)
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DROP:
            begin
                if (go)
                begin
                    load_drop  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_res || load_drop)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_idx_reg     <= OUT_IDX_W'(hit_idx_reg);
            out_created_reg <= is_new_reg;
            out_drop_reg    <= 1'b0;
            out_pkt_reg     <= new_row.pkt_cnt;
            out_byte_reg    <= new_row.byte_cnt;
            out_first_reg   <= new_row.first_time;
            out_last_reg    <= new_row.last_time;
            out_state_reg   <= new_row.tcp_state;
            out_est_reg     <= (32'(est_after) > 32'(EST_SAT)) ? OUT_EST_W'(EST_SAT)
                                                               : OUT_EST_W'(est_after);
        end
        else if (load_drop)
        begin
            out_idx_reg     <= '0;
            out_created_reg <= 1'b0;
            out_drop_reg    <= 1'b1;
            out_pkt_reg     <= '0;
            out_byte_reg    <= '0;
            out_first_reg   <= '0;
            out_last_reg    <= '0;
            out_state_reg   <= '0;
            out_est_reg     <= (32'(est_cnt_reg) > 32'(EST_SAT)) ? OUT_EST_W'(EST_SAT)
                                                                 : OUT_EST_W'(est_cnt_reg);
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.entry_index       = out_idx_reg;
    assign res.created_flow      = out_created_reg;
    assign res.table_full_drop   = out_drop_reg;
    assign res.packet_total      = out_pkt_reg;
    assign res.byte_total        = out_byte_reg;
    assign res.first_time        = out_first_reg;
    assign res.last_time         = out_last_reg;
    assign res.connection_state  = out_state_reg;
    assign res.established_count = out_est_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Established flows never outnumber allocated flows
    a_est_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        est_cnt_reg <= fill_cnt_reg)
        else $error("established count exceeds allocated flows");

    // Established count moves by at most one per transaction
    a_est_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (est_cnt_reg == $past(est_cnt_reg) ||
             est_cnt_reg == $past(est_cnt_reg) + 1'b1 ||
             est_cnt_reg == $past(est_cnt_reg) - 1'b1))
        else $error("established count jumped");

    // An allocation grows the fill count by exactly one
    a_alloc_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && is_new_reg) |=> (fill_cnt_reg == $past(fill_cnt_reg) + 1'b1))
        else $error("allocation did not advance fill count");

    // A drop is reported only with the table full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        load_drop |-> (fill_cnt_reg == CNT_W'(TABLE_ENTRIES)))
        else $error("drop with free entries");

    // The row memory is never read and written in the same cycle
    a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("entry memory read and write collide");

endmodule
`default_nettype wire
